// ===== src/ycc_pkg.sv =====
// package: payload types, fixed-point weights and the clamp shared by the converter
package ycc_pkg;

  localparam int FracBits = 16;
  localparam int QW       = 26;  // signed width of a per-pixel q.16 value
  localparam int CW       = 24;  // width of a clamped q.16 value, 0 .. 255 << 16
  localparam int SW       = 26;  // width of a four-pixel chroma sum
  localparam int Lanes    = 4;

  localparam logic signed [QW-1:0] LumaOffs   = QW'(16 <<< FracBits);
  localparam logic signed [QW-1:0] ChromaOffs = QW'(128 <<< FracBits);
  localparam logic signed [QW-1:0] TopQ       = QW'(255 <<< FracBits);

  // bt.601 weights folded with 219/255 and 224/255
  localparam logic signed [QW-1:0] YR  = QW'(16829);
  localparam logic signed [QW-1:0] YG  = QW'(33039);
  localparam logic signed [QW-1:0] YB  = QW'(6416);
  localparam logic signed [QW-1:0] CbR = QW'(9714);
  localparam logic signed [QW-1:0] CbG = QW'(19071);
  localparam logic signed [QW-1:0] CbB = QW'(28785);
  localparam logic signed [QW-1:0] CrR = QW'(28785);
  localparam logic signed [QW-1:0] CrG = QW'(24104);
  localparam logic signed [QW-1:0] CrB = QW'(4681);

  typedef struct packed {
    logic [7:0] red_0;
    logic [7:0] green_0;
    logic [7:0] blue_0;
    logic [7:0] red_1;
    logic [7:0] green_1;
    logic [7:0] blue_1;
    logic [7:0] red_2;
    logic [7:0] green_2;
    logic [7:0] blue_2;
    logic [7:0] red_3;
    logic [7:0] green_3;
    logic [7:0] blue_3;
  } blk_in_t;

  typedef struct packed {
    logic [7:0] luma_0;
    logic [7:0] luma_1;
    logic [7:0] luma_2;
    logic [7:0] luma_3;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } blk_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0]    luma;
    logic [CW-1:0] cb;
    logic [CW-1:0] cr;
  } lane_t;

  function automatic logic [CW-1:0] limit_q(input logic signed [QW-1:0] v);
    logic [CW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > TopQ) begin
      res = TopQ[CW-1:0];
    end else begin
      res = v[CW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== src/ycc_in_if.sv =====
// interface: input channel carrying one 2x2 rgb block per item
interface ycc_in_if;
  logic             valid;
  logic             ready;
  ycc_pkg::blk_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ycc_out_if.sv =====
// interface: output channel carrying four luma values and one chroma pair per item
interface ycc_out_if;
  logic              valid;
  logic              ready;
  ycc_pkg::blk_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ycc_lane.sv =====
// module: one pixel lane, rgb to clamped q.16 y/cb/cr with rounded luma, registered
module ycc_lane (
  input  logic          clk,
  input  logic          en,
  input  ycc_pkg::rgb_t px,
  output ycc_pkg::lane_t res
);
  import ycc_pkg::*;

  logic signed [QW-1:0] r_s;
  logic signed [QW-1:0] g_s;
  logic signed [QW-1:0] b_s;
  logic signed [QW-1:0] y_q;
  logic signed [QW-1:0] cb_q;
  logic signed [QW-1:0] cr_q;
  logic [CW-1:0]        y_lim;
  logic [CW-1:0]        y_rnd;
  lane_t                res_next;

  assign r_s = QW'($signed({1'b0, px.red}));
  assign g_s = QW'($signed({1'b0, px.green}));
  assign b_s = QW'($signed({1'b0, px.blue}));

  assign y_q  = LumaOffs + YR * r_s + YG * g_s + YB * b_s;
  assign cb_q = ChromaOffs - CbR * r_s - CbG * g_s + CbB * b_s;
  assign cr_q = ChromaOffs + CrR * r_s - CrG * g_s - CrB * b_s;

  // round half up, clamped value stays below 2^24 after the add
  assign y_lim = limit_q(y_q);
  assign y_rnd = y_lim + CW'(1 << (FracBits - 1));

  always_comb begin
    res_next.luma = y_rnd[FracBits +: 8];
    res_next.cb   = limit_q(cb_q);
    res_next.cr   = limit_q(cr_q);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

// ===== src/ycc_merge.sv =====
// module: merge stage, averages lane chroma into one 4:2:0 pair and registers the result
module ycc_merge (
  input  logic              clk,
  input  logic              en,
  input  ycc_pkg::lane_t    lane [ycc_pkg::Lanes],
  output ycc_pkg::blk_out_t res
);
  import ycc_pkg::*;

  logic [SW-1:0] cb_sum;
  logic [SW-1:0] cr_sum;
  blk_out_t      res_next;

  // sum of four plus half of the 2^18 divisor, max stays below 2^26
  always_comb begin
    cb_sum = SW'(1 << (FracBits + 1));
    cr_sum = SW'(1 << (FracBits + 1));
    for (int k = 0; k < Lanes; k++) begin
      cb_sum = cb_sum + SW'(lane[k].cb);
      cr_sum = cr_sum + SW'(lane[k].cr);
    end
  end

  always_comb begin
    res_next.luma_0      = lane[0].luma;
    res_next.luma_1      = lane[1].luma;
    res_next.luma_2      = lane[2].luma;
    res_next.luma_3      = lane[3].luma;
    res_next.chroma_blue = cb_sum[FracBits+2 +: 8];
    res_next.chroma_red  = cr_sum[FracBits+2 +: 8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

// ===== src/rgb_to_ycbcr420_block.sv =====
// top level: 2x2 rgb block to bt.601 studio-range luma and 4:2:0 chroma
//
// one item is a 2x2 block of 8-bit rgb pixels (top-left, top-right, bottom-left,
// bottom-right); each result item holds four luma values in 16..235 and one
// averaged cb/cr pair in 16..240. the block takes one item per clock while the
// sink takes results: four pixel lanes convert the pixels in parallel into
// q.16 values (constant-weight multiplies, clamp, luma rounding) and register
// them, then the merge stage sums the four chroma values, rounds half up and
// holds the result in the output register. the input is held off only when both
// stages hold an item and the sink is not ready; a stage that is empty or moving
// on lets the next item in during the same cycle. no state survives between
// items, and reset only clears the stage valid flags.
module rgb_to_ycbcr420_block (
  input  logic   clk,
  input  logic   rst,
  ycc_in_if.sink   pix,
  ycc_out_if.source ycc
);
  import ycc_pkg::*;

  rgb_t  px   [Lanes];
  lane_t lane [Lanes];

  logic s1_valid;
  logic s2_valid;
  logic s1_adv;
  logic s0_adv;

  // stage 2 moves when the output is empty or being taken
  assign s1_adv    = !s2_valid || ycc.ready;
  assign s0_adv    = !s1_valid || s1_adv;
  assign pix.ready = s0_adv;
  assign ycc.valid = s2_valid;

  // split the block into its four pixels
  always_comb begin
    px[0] = '{red: pix.data.red_0, green: pix.data.green_0, blue: pix.data.blue_0};
    px[1] = '{red: pix.data.red_1, green: pix.data.green_1, blue: pix.data.blue_1};
    px[2] = '{red: pix.data.red_2, green: pix.data.green_2, blue: pix.data.blue_2};
    px[3] = '{red: pix.data.red_3, green: pix.data.green_3, blue: pix.data.blue_3};
  end

  // per-pixel lanes, loaded whenever stage 1 can take a new item
  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    ycc_lane u_lane (
      .clk (clk),
      .en  (s0_adv),
      .px  (px[k]),
      .res (lane[k])
    );
  end

  // chroma average and output register
  ycc_merge u_merge (
    .clk  (clk),
    .en   (s1_adv),
    .lane (lane),
    .res  (ycc.data)
  );

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s0_adv) begin
        s1_valid <= pix.valid;
      end
      if (s1_adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // accepted item shows up in stage 1
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> s1_valid)
    else $error("accepted item lost before stage 1");

  // a stalled stage 1 item is kept
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("stalled stage 1 item dropped");

  // empty first stage never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> pix.ready)
    else $error("input blocked with empty pipeline");

  // results stay in studio range; only luma_0 and luma_3 are checked for luma
  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    ycc.valid |-> (ycc.data.luma_0 >= 8'd16 && ycc.data.luma_0 <= 8'd235 &&
                   ycc.data.luma_3 >= 8'd16 && ycc.data.luma_3 <= 8'd235))
    else $error("luma out of range");

  a_chroma_range: assert property (@(posedge clk) disable iff (rst)
    ycc.valid |-> (ycc.data.chroma_blue >= 8'd16 && ycc.data.chroma_blue <= 8'd240 &&
                   ycc.data.chroma_red >= 8'd16 && ycc.data.chroma_red <= 8'd240))
    else $error("chroma out of range");

endmodule

// ===== tb/tb_rgb_to_ycbcr420_block.sv =====
// testbench: 2x2 rgb block to bt.601 luma and 4:2:0 chroma, checked against a fixed-point predictor
`timescale 1ns / 1ps

module tb_rgb_to_ycbcr420_block;
  import ycc_pkg::*;

  // one row of the directed table; known rows carry a hand-computed result
  typedef struct {
    blk_in_t  blk;
    bit       known;
    blk_out_t ycc;
  } dir_row_t;

  localparam int       RandomBlocks = 1300;
  localparam int       MaxWait      = 18;
  localparam blk_out_t NoYcc        = '0;

  logic clk;
  logic rst;

  ycc_in_if  pix_if ();
  ycc_out_if ycc_if ();

  rgb_to_ycbcr420_block u_top (
    .clk (clk),
    .rst (rst),
    .pix (pix_if),
    .ycc (ycc_if)
  );

  // results still owed by the block, oldest first
  blk_out_t ycc_expected_q[$];
  blk_out_t want_ycc;
  int       errors;

  // side info that travels with the item on the input channel
  bit       row_known;
  blk_out_t row_ycc;

  // when set, that side runs without idle cycles
  bit src_calm;
  bit snk_calm;

  string ycc_field_names [6] = '{"luma_0", "luma_1", "luma_2", "luma_3",
                                 "chroma_blue", "chroma_red"};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // q.16 clamp to 0 .. 255 << 16
  function automatic int clamp_q16(input int v);
    if (v < 0) return 0;
    if (v > (255 <<< 16)) return 255 <<< 16;
    return v;
  endfunction

  // fixed-point conversion of one block: per-pixel luma, averaged chroma
  function automatic blk_out_t ycc_of_block(input blk_in_t blk);
    blk_out_t o;
    rgb_t     p;
    int       r, g, b, y, k;
    int       cb_sum, cr_sum;
    cb_sum = 0;
    cr_sum = 0;
    o = '0;
    for (k = 0; k < 4; k++) begin
      p = blk[95-24*k -: 24];
      r = int'(p.red);
      g = int'(p.green);
      b = int'(p.blue);
      y = clamp_q16((16 <<< 16) + 16829 * r + 33039 * g + 6416 * b);
      o[47-8*k -: 8] = 8'((y + 32768) >>> 16);
      cb_sum += clamp_q16((128 <<< 16) - 9714 * r - 19071 * g + 28785 * b);
      cr_sum += clamp_q16((128 <<< 16) + 28785 * r - 24104 * g - 4681 * b);
    end
    // mean of four unrounded values, round half up
    o.chroma_blue = 8'((cb_sum + (1 <<< 17)) >>> 18);
    o.chroma_red  = 8'((cr_sum + (1 <<< 17)) >>> 18);
    return o;
  endfunction

  function automatic blk_in_t uniform_block(input logic [7:0] r, g, b);
    return {4{r, g, b}};
  endfunction

  // byte biased toward the ends of the range
  function automatic logic [7:0] extreme_byte();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(252, 255));
    endcase
  endfunction

  // random block: plain noise, extremes, gray pixels or one flat color
  function automatic blk_in_t rand_block();
    blk_in_t    blk;
    rgb_t       px;
    logic [7:0] gray;
    int         kind, k;
    kind = $urandom_range(0, 9);
    px   = '0;
    blk  = '0;
    for (k = 0; k < 4; k++) begin
      if (kind <= 5) begin
        px = 24'($urandom);
      end else if (kind <= 7) begin
        px = {extreme_byte(), extreme_byte(), extreme_byte()};
      end else if (kind == 8) begin
        gray = 8'($urandom);
        px   = {gray, gray, gray};
      end else if (k == 0) begin
        px = 24'($urandom);
      end
      blk[95-24*k -: 24] = px;
    end
    return blk;
  endfunction

  // present one item after a random gap and hold it until taken
  task automatic send_block(input blk_in_t blk, input bit known, input blk_out_t ycc);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, MaxWait);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.data  <= blk;
    row_known    <= known;
    row_ycc      <= ycc;
    pix_if.valid <= 1'b1;
    do @(posedge clk); while (!(pix_if.valid && pix_if.ready));
    @(negedge clk);
  endtask

  // stop sending until every owed result is out
  task automatic drain_results();
    pix_if.valid <= 1'b0;
    while (ycc_expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // output side: random stall before each result
  initial begin : sink_side
    int stall;
    ycc_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = snk_calm ? 0 : $urandom_range(0, MaxWait);
      if (stall > 0) begin
        ycc_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      ycc_if.ready <= 1'b1;
      do @(posedge clk); while (!(ycc_if.valid && ycc_if.ready));
      @(negedge clk);
    end
  end

  // check the result first, then log the item taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (ycc_if.valid && ycc_if.ready) begin
        if (ycc_expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, ycc_if.data);
          errors++;
        end else begin
          want_ycc = ycc_expected_q.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (ycc_if.data[47-8*i -: 8] !== want_ycc[47-8*i -: 8]) begin
              $display("%0t: %s expected %0d got %0d", $time, ycc_field_names[i],
                       want_ycc[47-8*i -: 8], ycc_if.data[47-8*i -: 8]);
              errors++;
            end
          end
        end
      end
      if (pix_if.valid && pix_if.ready) begin
        ycc_expected_q.push_back(row_known ? row_ycc : ycc_of_block(pix_if.data));
      end
    end
  end

  initial begin : stimulus
    dir_row_t rows[$];
    int       i;

    rst          = 1'b1;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    row_known    = 1'b0;
    row_ycc      = '0;
    src_calm     = 1'b0;
    snk_calm     = 1'b0;
    errors       = 0;

    // flat blocks with results read off directly
    rows.push_back('{uniform_block(8'd0, 8'd0, 8'd0), 1'b1,
                     {8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128}});
    rows.push_back('{uniform_block(8'd255, 8'd255, 8'd255), 1'b1,
                     {8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128}});
    rows.push_back('{uniform_block(8'd255, 8'd0, 8'd0), 1'b1,
                     {8'd81, 8'd81, 8'd81, 8'd81, 8'd90, 8'd240}});
    rows.push_back('{uniform_block(8'd0, 8'd255, 8'd0), 1'b1,
                     {8'd145, 8'd145, 8'd145, 8'd145, 8'd54, 8'd34}});
    rows.push_back('{uniform_block(8'd0, 8'd0, 8'd255), 1'b1,
                     {8'd41, 8'd41, 8'd41, 8'd41, 8'd240, 8'd110}});
    // predicted rows
    rows.push_back('{uniform_block(8'd128, 8'd128, 8'd128), 1'b0, NoYcc});
    rows.push_back('{uniform_block(8'd0, 8'd255, 8'd255), 1'b0, NoYcc});
    rows.push_back('{uniform_block(8'd255, 8'd0, 8'd255), 1'b0, NoYcc});
    rows.push_back('{uniform_block(8'd255, 8'd255, 8'd0), 1'b0, NoYcc});
    rows.push_back('{blk_in_t'({24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffffff}),
                     1'b0, NoYcc});
    rows.push_back('{blk_in_t'({24'hffffff, 24'h000000, 24'h000000, 24'hffffff}),
                     1'b0, NoYcc});
    rows.push_back('{blk_in_t'({24'hffffff, 24'h000000, 24'h000000, 24'h000000}),
                     1'b0, NoYcc});
    rows.push_back('{blk_in_t'({24'h000000, 24'hffffff, 24'h000000, 24'h000000}),
                     1'b0, NoYcc});
    rows.push_back('{blk_in_t'({24'h000000, 24'h000000, 24'hffffff, 24'h000000}),
                     1'b0, NoYcc});
    rows.push_back('{blk_in_t'({24'h000000, 24'h000000, 24'h000000, 24'hffffff}),
                     1'b0, NoYcc});
    rows.push_back('{blk_in_t'({12{8'haa}}), 1'b0, NoYcc});
    rows.push_back('{blk_in_t'({12{8'h55}}), 1'b0, NoYcc});
    rows.push_back('{blk_in_t'({24'h000000, 24'h555555, 24'haaaaaa, 24'hffffff}),
                     1'b0, NoYcc});
    rows.push_back('{blk_in_t'({24'h010101, 24'h7f7f7f, 24'h808080, 24'hfefefe}),
                     1'b0, NoYcc});

    // synchronous reset, released at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[j]) send_block(rows[j].blk, rows[j].known, rows[j].ycc);

    // let the pipeline empty completely once before the random part
    drain_results();

    for (i = 0; i < RandomBlocks; i++) begin
      // change the idling pattern of each side every hundred items
      if (i % 100 == 0) begin
        src_calm = ($urandom_range(0, 3) == 0);
        snk_calm = ($urandom_range(0, 3) == 0);
      end
      if (i == RandomBlocks / 2) drain_results();
      send_block(rand_block(), 1'b0, NoYcc);
    end

    drain_results();
    // keep clocking after the drain to catch any stray result
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
